// ----- rtl/lprd_pkg.sv -----
// Package for the lidar point record decoder: types, constants, CORDIC table.
// No dependencies.
package lprd_pkg;

   localparam int HdrLen = 6;
   localparam int RecLen = 22;
   localparam logic signed [63:0] CordicGain = 64'sd652032874;
   localparam logic signed [63:0] CoordMax = 64'sd4294967295;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_AZ,
      ST_EL,
      ST_MUL1,
      ST_MUL2,
      ST_OUT
   } state_type;

   typedef struct packed {
      logic load_angle_az;
      logic load_angle_el;
      logic step;
      logic mul1;
      logic mul2;
   } cmd_type;

   typedef struct packed {
      logic steps_done;
   } status_type;

   function automatic logic [7:0] hdr_char(input logic [2:0] idx);
      logic [7:0] c;
      begin
         case (idx)
            3'd0: c = 8'h45;
            3'd1: c = 8'h42;
            3'd2: c = 8'h52;
            3'd3: c = 8'h42;
            3'd4: c = 8'h45;
            3'd5: c = 8'h50;
            default: c = 8'h00;
         endcase
         return c;
      end
   endfunction

   function automatic logic [31:0] atan_turn(input logic [5:0] i);
      logic [31:0] t;
      begin
         case (i)
            6'd0: t = 32'h20000000;
            6'd1: t = 32'h12E4051E;
            6'd2: t = 32'h09FB385B;
            6'd3: t = 32'h051111D4;
            6'd4: t = 32'h028B0D43;
            6'd5: t = 32'h0145D7E1;
            6'd6: t = 32'h00A2F61E;
            6'd7: t = 32'h00517C55;
            6'd8: t = 32'h0028BE53;
            6'd9: t = 32'h00145F2F;
            6'd10: t = 32'h000A2F98;
            6'd11: t = 32'h000517CC;
            6'd12: t = 32'h00028BE6;
            6'd13: t = 32'h000145F3;
            6'd14: t = 32'h0000A2FA;
            6'd15: t = 32'h0000517D;
            6'd16: t = 32'h000028BE;
            6'd17: t = 32'h0000145F;
            6'd18: t = 32'h00000A30;
            6'd19: t = 32'h00000518;
            6'd20: t = 32'h0000028C;
            6'd21: t = 32'h00000146;
            6'd22: t = 32'h000000A3;
            6'd23: t = 32'h00000051;
            6'd24: t = 32'h00000029;
            6'd25: t = 32'h00000014;
            6'd26: t = 32'h0000000A;
            6'd27: t = 32'h00000005;
            6'd28: t = 32'h00000003;
            6'd29: t = 32'h00000001;
            6'd30: t = 32'h00000001;
            default: t = 32'h00000000;
         endcase
         return t;
      end
   endfunction

endpackage

// ----- rtl/lprd_if.sv -----
// Valid/ready stream interfaces for the decoder's byte input and point output.
// Depends on nothing.
interface lprd_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] data_byte;
   logic       last_byte;
   modport source(output valid, output data_byte, output last_byte, input ready);
   modport sink(input valid, input data_byte, input last_byte, output ready);
endinterface

interface lprd_rsp_if;
   logic               valid;
   logic               ready;
   logic               item_kind;
   logic signed [32:0] pos_x;
   logic signed [32:0] pos_y;
   logic signed [32:0] pos_z;
   logic [31:0]        time_raw;
   logic [15:0]        amplitude_raw;
   logic [15:0]        reflect_raw;
   logic [15:0]        shape_dev;
   logic               run_end;
   modport source(output valid, output item_kind, output pos_x, output pos_y,
      output pos_z, output time_raw, output amplitude_raw, output reflect_raw,
      output shape_dev, output run_end, input ready);
   modport sink(input valid, input item_kind, input pos_x, input pos_y,
      input pos_z, input time_raw, input amplitude_raw, input reflect_raw,
      input shape_dev, input run_end, output ready);
endinterface

// ----- rtl/lidar_point_record_decoder_top.sv -----
// Top level of the lidar point record decoder: byte parser, record buffer,
// packet tally and output register. Depends on lprd_pkg, lprd_if, lprd_ctrl, lprd_dp.
//
//   Channel | Direction | Carries
//   req     | in        | one datagram byte and its last flag per beat
//   rsp     | out       | one point or cloud-end marker per beat
//   csr     | in        | packets_per_cloud write
//
// Header and record bytes are taken one per cycle. The final byte of a record
// with non-zero depth starts the coordinate unit, which holds the input through
// two passes of the shared CORDIC rotator, then two multiply stages and the
// output hand-off. The input also waits while the output register holds an
// untaken beat. Reset is synchronous, active high, and clears all control
// state; the record buffer needs no reset.
module lidar_point_record_decoder_top #(
   parameter int CORDIC_STEPS = 32
) (
   input  logic       clock,
   input  logic       reset,
   lprd_req_if.sink   req,
   lprd_rsp_if.source rsp,
   input  logic       csr_write_enable,
   input  logic [7:0] csr_write_data
);
   logic [7:0]  ppc_ff;
   logic [2:0]  hdr_pos_ff;
   logic        rej_ff;
   logic [4:0]  rec_pos_ff;
   logic [7:0]  rec_ff [lprd_pkg::RecLen];
   logic [7:0]  tally_ff;
   logic        mark_pend_ff;

   logic        out_valid_ff;
   logic        out_kind_ff;
   logic        out_end_ff;
   logic signed [32:0] ox_ff, oy_ff, oz_ff;
   logic [31:0] otime_ff;
   logic [15:0] oamp_ff, oref_ff, oshape_ff;

   logic        accept, busy, done, start, out_free, rec_done, good_last, emit_mark;
   logic        hdr_ok;
   logic [31:0] depth_w;
   logic [7:0]  tally_inc;
   lprd_pkg::cmd_type    cmd;
   lprd_pkg::status_type status;
   logic signed [32:0] px, py, pz;

   assign out_free = !out_valid_ff || rsp.ready;
   // While a marker waits behind a point, the input stays closed.
   assign req.ready = !busy && !mark_pend_ff && out_free;
   assign accept = req.valid && req.ready;

   assign rec_done = accept && hdr_pos_ff == 3'(lprd_pkg::HdrLen) && !rej_ff
      && rec_pos_ff == 5'(lprd_pkg::RecLen - 1);
   assign depth_w = {rec_ff[12], rec_ff[13], rec_ff[14], rec_ff[15]};
   // The depth's last byte arrives early, so the depth is complete at the record end.
   assign start = rec_done && depth_w != 32'd0;

   // The header counts as complete when this beat is its last matching byte,
   // so a packet made of the header alone is still counted.
   assign hdr_ok = hdr_pos_ff == 3'(lprd_pkg::HdrLen)
      || (hdr_pos_ff == 3'(lprd_pkg::HdrLen - 1)
          && req.data_byte == lprd_pkg::hdr_char(hdr_pos_ff));
   assign good_last = accept && req.last_byte && hdr_ok && !rej_ff;
   assign tally_inc = tally_ff + 8'd1;
   assign emit_mark = good_last && tally_inc >= ppc_ff;

   lprd_ctrl u_ctrl (
      .clock(clock), .reset(reset), .start(start), .out_free(out_free),
      .status(status), .cmd(cmd), .busy(busy), .done(done)
   );

   lprd_dp #(.CORDIC_STEPS(CORDIC_STEPS)) u_dp (
      .clock(clock), .cmd(cmd),
      .az_angle({rec_ff[4], rec_ff[5], rec_ff[6], rec_ff[7]}),
      .el_angle({rec_ff[8], rec_ff[9], rec_ff[10], rec_ff[11]}),
      .depth(depth_w), .status(status),
      .pos_x(px), .pos_y(py), .pos_z(pz)
   );

   always_ff @(posedge clock) begin
      if (accept && hdr_pos_ff == 3'(lprd_pkg::HdrLen) && !rej_ff) begin
         rec_ff[rec_pos_ff] <= req.data_byte;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ppc_ff <= 8'd1;
         hdr_pos_ff <= '0;
         rej_ff <= 1'b0;
         rec_pos_ff <= '0;
         tally_ff <= '0;
         mark_pend_ff <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         if (csr_write_enable) ppc_ff <= csr_write_data;
         if (rsp.ready) out_valid_ff <= 1'b0;
         if (accept) begin
            if (hdr_pos_ff != 3'(lprd_pkg::HdrLen)) begin
               if (req.data_byte != lprd_pkg::hdr_char(hdr_pos_ff)) rej_ff <= 1'b1;
               hdr_pos_ff <= hdr_pos_ff + 3'd1;
            end else if (!rej_ff) begin
               rec_pos_ff <= rec_done ? 5'd0 : rec_pos_ff + 5'd1;
            end
            if (good_last) tally_ff <= emit_mark ? 8'd0 : tally_inc;
            if (req.last_byte) begin
               hdr_pos_ff <= '0;
               rej_ff <= 1'b0;
               rec_pos_ff <= '0;
            end
            if (emit_mark) begin
               if (start) begin
                  mark_pend_ff <= 1'b1;
               end else begin
                  out_valid_ff <= 1'b1;
                  out_kind_ff <= 1'b1;
                  out_end_ff <= 1'b1;
                  ox_ff <= '0; oy_ff <= '0; oz_ff <= '0;
                  otime_ff <= '0; oamp_ff <= '0; oref_ff <= '0; oshape_ff <= '0;
               end
            end
         end
         if (done) begin
            out_valid_ff <= 1'b1;
            out_kind_ff <= 1'b0;
            out_end_ff <= !mark_pend_ff;
            ox_ff <= px; oy_ff <= py; oz_ff <= pz;
            otime_ff <= {rec_ff[0], rec_ff[1], rec_ff[2], rec_ff[3]};
            oamp_ff <= {rec_ff[16], rec_ff[17]};
            oref_ff <= {rec_ff[18], rec_ff[19]};
            oshape_ff <= {rec_ff[20], rec_ff[21]};
         end else if (mark_pend_ff && !busy && out_free) begin
            mark_pend_ff <= 1'b0;
            out_valid_ff <= 1'b1;
            out_kind_ff <= 1'b1;
            out_end_ff <= 1'b1;
            ox_ff <= '0; oy_ff <= '0; oz_ff <= '0;
            otime_ff <= '0; oamp_ff <= '0; oref_ff <= '0; oshape_ff <= '0;
         end
      end
   end

   assign rsp.valid = out_valid_ff;
   assign rsp.item_kind = out_kind_ff;
   assign rsp.pos_x = ox_ff;
   assign rsp.pos_y = oy_ff;
   assign rsp.pos_z = oz_ff;
   assign rsp.time_raw = otime_ff;
   assign rsp.amplitude_raw = oamp_ff;
   assign rsp.reflect_raw = oref_ff;
   assign rsp.shape_dev = oshape_ff;
   assign rsp.run_end = out_end_ff;
endmodule

// ----- rtl/lprd_ctrl.sv -----
// Sequencer for one record's coordinate computation.
// Depends on lprd_pkg.
module lprd_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   input  logic                 out_free,
   input  lprd_pkg::status_type status,
   output lprd_pkg::cmd_type    cmd,
   output logic                 busy,
   output logic                 done
);
   lprd_pkg::state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= lprd_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      cmd = '0;
      busy = 1'b1;
      done = 1'b0;
      case (state_ff)
         lprd_pkg::ST_IDLE: begin
            busy = 1'b0;
            if (start) begin
               cmd.load_angle_az = 1'b1;
               state_in = lprd_pkg::ST_AZ;
            end
         end
         lprd_pkg::ST_AZ: begin
            cmd.step = 1'b1;
            if (status.steps_done) begin
               cmd.step = 1'b0;
               cmd.load_angle_el = 1'b1;
               state_in = lprd_pkg::ST_EL;
            end
         end
         lprd_pkg::ST_EL: begin
            cmd.step = 1'b1;
            if (status.steps_done) begin
               cmd.step = 1'b0;
               state_in = lprd_pkg::ST_MUL1;
            end
         end
         lprd_pkg::ST_MUL1: begin
            cmd.mul1 = 1'b1;
            state_in = lprd_pkg::ST_MUL2;
         end
         lprd_pkg::ST_MUL2: begin
            cmd.mul2 = 1'b1;
            state_in = lprd_pkg::ST_OUT;
         end
         lprd_pkg::ST_OUT: begin
            if (out_free) begin
               done = 1'b1;
               state_in = lprd_pkg::ST_IDLE;
            end
         end
         default: state_in = lprd_pkg::ST_IDLE;
      endcase
   end
endmodule

// ----- rtl/lprd_dp.sv -----
// Datapath: shared CORDIC rotator, Q30 products and depth scaling.
// Depends on lprd_pkg.
module lprd_dp #(
   parameter int CORDIC_STEPS = 32
) (
   input  logic              clock,
   input  lprd_pkg::cmd_type cmd,
   input  logic [31:0]       az_angle,
   input  logic [31:0]       el_angle,
   input  logic [31:0]       depth,
   output lprd_pkg::status_type status,
   output logic signed [32:0] pos_x,
   output logic signed [32:0] pos_y,
   output logic signed [32:0] pos_z
);
   localparam int StepW = $clog2(CORDIC_STEPS + 1);

   logic signed [63:0] x_ff, x_in, y_ff, y_in, z_ff, z_in;
   logic               flip_ff, flip_in;
   logic [StepW-1:0]   step_ff, step_in;
   logic signed [63:0] caz_ff, saz_ff;
   logic signed [63:0] xq_ff, yq_ff, zq_ff;
   logic signed [32:0] px_ff, py_ff, pz_ff;
   logic signed [63:0] fx, fy;
   logic signed [63:0] ang;
   logic [31:0]        angle_sel;
   logic signed [63:0] tt;
   logic signed [63:0] sx, sy;

   function automatic logic signed [63:0] rnd30(input logic signed [65:0] v);
      logic signed [65:0] t;
      begin
         t = (v + 66'sd536870912) >>> 30;
         return t[63:0];
      end
   endfunction

   // Signed 33 by 33 product; every operand here fits in 33 bits.
   function automatic logic signed [65:0] mul33(input logic signed [32:0] a,
                                                input logic signed [32:0] b);
      begin
         return a * b;
      end
   endfunction

   function automatic logic signed [32:0] sat(input logic signed [63:0] r);
      logic signed [63:0] c;
      begin
         c = r;
         if (r > lprd_pkg::CoordMax) c = lprd_pkg::CoordMax;
         if (r < -lprd_pkg::CoordMax) c = -lprd_pkg::CoordMax;
         return c[32:0];
      end
   endfunction

   assign status.steps_done = (step_ff == StepW'(CORDIC_STEPS));
   assign fx = status.steps_done ? (flip_ff ? -x_ff : x_ff) : x_ff;
   assign fy = flip_ff ? -y_ff : y_ff;

   always_comb begin
      angle_sel = cmd.load_angle_el ? el_angle : az_angle;
      ang = 64'(signed'(angle_sel));
      flip_in = 1'b0;
      if (ang > 64'sd1073741824) begin
         ang = ang - 64'sd2147483648;
         flip_in = 1'b1;
      end else if (ang < -64'sd1073741824) begin
         ang = ang + 64'sd2147483648;
         flip_in = 1'b1;
      end
      tt = (32'(step_ff) < 32'd32) ? 64'(lprd_pkg::atan_turn(6'(step_ff))) : 64'sd0;
      sx = x_ff >>> step_ff;
      sy = y_ff >>> step_ff;
      x_in = x_ff;
      y_in = y_ff;
      z_in = z_ff;
      step_in = step_ff;
      if (cmd.load_angle_az || cmd.load_angle_el) begin
         x_in = lprd_pkg::CordicGain;
         y_in = '0;
         z_in = ang;
         step_in = '0;
      end else if (cmd.step) begin
         if (z_ff >= 0) begin
            x_in = x_ff - sy;
            y_in = y_ff + sx;
            z_in = z_ff - tt;
         end else begin
            x_in = x_ff + sy;
            y_in = y_ff - sx;
            z_in = z_ff + tt;
         end
         step_in = step_ff + 1'b1;
      end
      if (!(cmd.load_angle_az || cmd.load_angle_el)) flip_in = flip_ff;
   end

   always_ff @(posedge clock) begin
      x_ff <= x_in;
      y_ff <= y_in;
      z_ff <= z_in;
      flip_ff <= flip_in;
      step_ff <= step_in;
      if (cmd.load_angle_el) begin
         caz_ff <= fx;
         saz_ff <= fy;
      end
      if (cmd.mul1) begin
         // Product of two Q30 values, each within about +-2^30.
         xq_ff <= rnd30(mul33(saz_ff[32:0], fx[32:0]));
         yq_ff <= rnd30(mul33(caz_ff[32:0], fx[32:0]));
         zq_ff <= fy;
      end
      if (cmd.mul2) begin
         px_ff <= sat(rnd30(mul33(xq_ff[32:0], {1'b0, depth})));
         py_ff <= sat(rnd30(mul33(yq_ff[32:0], {1'b0, depth})));
         pz_ff <= sat(rnd30(mul33(zq_ff[32:0], {1'b0, depth})));
      end
   end

   assign pos_x = px_ff;
   assign pos_y = py_ff;
   assign pos_z = pz_ff;
endmodule

// ----- rtl/lprd_checker.sv -----
// Port-level checks for the decoder, bound to the top level.
// Depends on lidar_point_record_decoder_top.
module lprd_checker (
   input logic clock,
   input logic reset,
   input logic req_ready,
   input logic rsp_valid,
   input logic rsp_ready,
   input logic rsp_item_kind,
   input logic rsp_run_end,
   input logic signed [32:0] rsp_pos_x
);
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid) else $error("rsp beat dropped");
   a_marker_end: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_item_kind |-> rsp_run_end) else $error("marker without run end");
   a_marker_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_item_kind |-> rsp_pos_x == 33'sd0) else $error("marker payload");
   a_reset_idle: assert property (@(posedge clock)
      $past(reset) |-> !rsp_valid) else $error("output after reset");
   a_input_closed: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |-> !req_ready) else $error("input open while output waits");
endmodule

bind lidar_point_record_decoder_top lprd_checker u_lprd_checker (
   .clock(clock), .reset(reset),
   .req_ready(req.ready),
   .rsp_valid(rsp.valid), .rsp_ready(rsp.ready),
   .rsp_item_kind(rsp.item_kind), .rsp_run_end(rsp.run_end),
   .rsp_pos_x(rsp.pos_x)
);
